FILE: hw/rtl/assert_macros.svh
// assertion macros used by the checker file
// no dependencies; each macro expects clk and rst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// property that must hold in the same cycle
`define KCC_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");
// cause in one cycle, effect in the next
`define KCC_ASSERT_NEXT(lbl, cause, effect) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cause) |=> (effect)) \
    else $error("assertion failed");
`endif

FILE: hw/rtl/kcc_pkg.sv
// shared constants, codes and types for the k-means color clustering block
// no dependencies
package kcc_pkg;
  localparam int MAX_PIXELS = 4096;
  localparam int PIX_AW     = $clog2(MAX_PIXELS);
  localparam int CNT_W      = PIX_AW + 1;
  localparam int NUM_CLUSTERS = 2;
  localparam int NUM_CEN    = NUM_CLUSTERS * 3;

  localparam int SQ_W   = 34;  // sum of three squared 16-bit differences
  localparam int DIST_W = 17;  // 9.8 distance
  localparam int DSUM_W = 29;  // sum of distances over the store
  localparam int CSUM_W = 20;  // per channel sum over the store
  localparam int CEN_W  = 16;  // 8.8 centre

  localparam logic [1:0] ACT_LOAD   = 2'd0;
  localparam logic [1:0] ACT_LABEL  = 2'd1;
  localparam logic [1:0] ACT_CENTRE = 2'd2;

  localparam logic [1:0] REG_STOP  = 2'd0;
  localparam logic [1:0] REG_MAXR  = 2'd1;

  localparam logic [1:0] ST_CONVERGED = 2'd0;
  localparam logic [1:0] ST_TOO_FEW   = 2'd1;
  localparam logic [1:0] ST_LIMIT     = 2'd2;

  localparam logic OP_SQRT = 1'b0;
  localparam logic OP_DIV  = 1'b1;

  typedef struct packed {
    logic              go;
    logic              op;
    logic [SQ_W-1:0]   opa;
    logic [CNT_W-1:0]  opb;
  } unit_req_t;

  typedef struct packed {
    logic              done;
    logic [DIST_W-1:0] result;
  } unit_rsp_t;
endpackage

FILE: hw/rtl/kcc_ram.sv
// generic single write port, single read port ram with registered read
// no dependencies
module kcc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

FILE: hw/rtl/kcc_sqdiv.sv
// iterative unit: integer square root (2 bits a step) or restoring division (1 bit a step)
// one shared compare and subtract; uses kcc_pkg
module kcc_sqdiv (
  input  logic               clk,
  input  logic               rst_n,
  input  kcc_pkg::unit_req_t req,
  output kcc_pkg::unit_rsp_t rsp
);
  localparam logic [4:0] SQRT_STEPS = 5'd17;
  localparam logic [4:0] DIV_STEPS  = 5'd29;

  logic                          run_r, done_r, op_r;
  logic [4:0]                    cnt_r;
  logic [kcc_pkg::SQ_W-1:0]      shreg_r;
  logic [19:0]                   rem_r;
  logic [28:0]                   res_r;
  logic [kcc_pkg::CNT_W-1:0]     opb_r;
  logic [19:0]                   cand, trial, diff;
  logic                          ge;

  always_comb begin
    if (op_r == kcc_pkg::OP_SQRT) begin
      cand  = {rem_r[17:0], shreg_r[33:32]};
      trial = {1'b0, res_r[16:0], 2'b01};
    end else begin
      cand  = {rem_r[18:0], shreg_r[33]};
      trial = {{(20-kcc_pkg::CNT_W){1'b0}}, opb_r};
    end
    ge   = (cand >= trial);
    diff = cand - trial;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= run_r && (cnt_r == 5'd0);
      if (req.go) begin
        run_r <= 1'b1;
      end else if (run_r && cnt_r == 5'd0) begin
        run_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.go) begin
      op_r  <= req.op;
      opb_r <= req.opb;
      rem_r <= '0;
      res_r <= '0;
      if (req.op == kcc_pkg::OP_SQRT) begin
        shreg_r <= req.opa;
        cnt_r   <= SQRT_STEPS - 5'd1;
      end else begin
        shreg_r <= {req.opa[28:0], 5'b0};
        cnt_r   <= DIV_STEPS - 5'd1;
      end
    end else if (run_r) begin
      rem_r <= ge ? diff : cand;
      res_r <= {res_r[27:0], ge};
      cnt_r <= cnt_r - 5'd1;
      if (op_r == kcc_pkg::OP_SQRT) begin
        shreg_r <= {shreg_r[31:0], 2'b00};
      end else begin
        shreg_r <= {shreg_r[32:0], 1'b0};
      end
    end
  end

  assign rsp.done   = done_r;
  assign rsp.result = res_r[16:0];
endmodule

FILE: hw/rtl/kmeans_color_clustering.sv
// k-means color clustering, two groups: a plain load keeps busy low, and a label or centre
// read passes through the read state and then strobes its registered result.
// the last load runs the clustering: per pixel in each assignment pass one shared multiplier
// forms 6 products, then a 17-step root follows, and the pass ends with a divide for the mean;
// each round adds an accumulate pass and up to 6 centre divides; then one result strobe.
// reset (synchronous, rst_n low) clears control, counts and centres; the receiver cannot stall
module kmeans_color_clustering (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_action,
  input  logic [7:0]  in_chan0,
  input  logic [7:0]  in_chan1,
  input  logic [7:0]  in_chan2,
  input  logic        in_last_pixel,
  input  logic [11:0] in_index,
  output logic        out_strobe,
  output logic        out_label,
  output logic [15:0] out_centre0,
  output logic [15:0] out_centre1,
  output logic [15:0] out_centre2,
  output logic [1:0]  out_status,
  output logic [7:0]  out_rounds_used,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [16:0] cfg_data
);
  localparam int CNT_W = kcc_pkg::CNT_W;
  localparam int AW    = kcc_pkg::PIX_AW;

  // sequencer codes
  localparam logic [4:0] S_IDLE     = 5'd0;
  localparam logic [4:0] S_RD       = 5'd1;
  localparam logic [4:0] S_SEED_RD  = 5'd2;
  localparam logic [4:0] S_SEED_CHK = 5'd3;
  localparam logic [4:0] S_CLR      = 5'd4;
  localparam logic [4:0] S_P_RD     = 5'd5;
  localparam logic [4:0] S_P_LAT    = 5'd6;
  localparam logic [4:0] S_P_MUL    = 5'd7;
  localparam logic [4:0] S_P_SQ     = 5'd8;
  localparam logic [4:0] S_P_SQW    = 5'd9;
  localparam logic [4:0] S_P_DIV    = 5'd10;
  localparam logic [4:0] S_DECIDE   = 5'd11;
  localparam logic [4:0] S_U_RD     = 5'd12;
  localparam logic [4:0] S_U_ACC    = 5'd13;
  localparam logic [4:0] S_U_DIV    = 5'd14;
  localparam logic [4:0] S_U_DW     = 5'd15;
  localparam logic [4:0] S_FIN      = 5'd16;

  logic [4:0] state_r;

  // configuration
  logic [16:0] stop_thr_r;
  logic [7:0]  max_rounds_r;

  // run control
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] idx_r;
  logic             run_done_r;
  logic             first_r;
  logic             use_min_r;
  logic [7:0]       round_r;
  logic [1:0]       status_r;
  logic [2:0]       mstep_r;
  logic [2:0]       cstep_r;
  logic             strobe_r;

  // datapath
  logic [kcc_pkg::CEN_W-1:0]  cen_r  [kcc_pkg::NUM_CEN];
  logic [kcc_pkg::CSUM_W-1:0] sums_r [kcc_pkg::NUM_CEN];
  logic [CNT_W-1:0]           mcnt_r [kcc_pkg::NUM_CLUSTERS];
  logic [23:0]                seed_r;
  logic [23:0]                pix_r;
  logic                       lab_r;
  logic [31:0]                prod_r;
  logic [kcc_pkg::SQ_W-1:0]   d0_r, d1_r;
  logic [kcc_pkg::DSUM_W-1:0] dsum_r;
  logic [16:0]                spread_r, prev_r;
  logic [1:0]                 rd_act_r;
  logic [11:0]                rd_idx_r;
  logic                       olab_r;
  logic [15:0]                ocen_r [3];

  logic accept;
  assign accept    = start && !busy;
  assign busy      = (state_r != S_IDLE);
  assign cfg_ready = 1'b1;

  // load side: the first load after a run starts a new image
  logic [CNT_W-1:0] count_eff;
  logic             pix_we;
  assign count_eff = run_done_r ? '0 : count_r;
  assign pix_we    = accept && (in_action == kcc_pkg::ACT_LOAD) && !count_eff[CNT_W-1];

  logic [23:0] pix_rdata;
  logic        lab_rdata;
  logic        lab_we, lab_wdata;
  logic [AW-1:0] lab_raddr;

  kcc_ram #(.WIDTH(24), .DEPTH(kcc_pkg::MAX_PIXELS)) u_pix_ram (
    .clk   (clk),
    .we    (pix_we),
    .waddr (count_eff[AW-1:0]),
    .wdata ({in_chan2, in_chan1, in_chan0}),
    .raddr (idx_r[AW-1:0]),
    .rdata (pix_rdata)
  );

  assign lab_raddr = (state_r == S_IDLE) ? in_index[AW-1:0] : idx_r[AW-1:0];

  kcc_ram #(.WIDTH(1), .DEPTH(kcc_pkg::MAX_PIXELS)) u_lab_ram (
    .clk   (clk),
    .we    (lab_we),
    .waddr (idx_r[AW-1:0]),
    .wdata (lab_wdata),
    .raddr (lab_raddr),
    .rdata (lab_rdata)
  );

  // shared root / divide unit
  kcc_pkg::unit_req_t req;
  kcc_pkg::unit_rsp_t rsp;
  kcc_sqdiv u_unit (.clk(clk), .rst_n(rst_n), .req(req), .rsp(rsp));

  // multiplier operands: product k is channel k mod 3 against centre entry k
  logic [7:0]  mul_ch;
  logic [15:0] mul_cen, mul_a, mul_diff;
  always_comb begin
    unique case (mstep_r)
      3'd0, 3'd3: mul_ch = pix_r[7:0];
      3'd1, 3'd4: mul_ch = pix_r[15:8];
      default:    mul_ch = pix_r[23:16];
    endcase
    unique case (mstep_r)
      3'd0:    mul_cen = cen_r[0];
      3'd1:    mul_cen = cen_r[1];
      3'd2:    mul_cen = cen_r[2];
      3'd3:    mul_cen = cen_r[3];
      3'd4:    mul_cen = cen_r[4];
      default: mul_cen = cen_r[5];
    endcase
    mul_a    = {mul_ch, 8'b0};
    mul_diff = (mul_a > mul_cen) ? (mul_a - mul_cen) : (mul_cen - mul_a);
  end

  // label choice: strictly nearer centre 1 wins, a tie stays at 0
  logic new_lab, dist_sel;
  assign new_lab  = (d1_r < d0_r);
  assign dist_sel = use_min_r ? new_lab : lab_r;

  logic [CNT_W-1:0] div_cnt;
  assign div_cnt = (cstep_r >= 3'd3) ? mcnt_r[1] : mcnt_r[0];

  logic [16:0] spread_diff;
  assign spread_diff = (spread_r > prev_r) ? (spread_r - prev_r) : (prev_r - spread_r);

  logic idx_last;
  assign idx_last = ((idx_r + 1'b1) == count_r);

  always_comb begin
    req     = '0;
    lab_we    = 1'b0;
    lab_wdata = 1'b0;
    unique case (state_r)
      S_CLR: begin
        lab_we = 1'b1;
      end
      S_P_SQ: begin
        req.go    = 1'b1;
        req.op    = kcc_pkg::OP_SQRT;
        req.opa   = dist_sel ? d1_r : d0_r;
        lab_we    = 1'b1;
        lab_wdata = new_lab;
      end
      S_P_SQW: begin
        req.go  = rsp.done && idx_last;
        req.op  = kcc_pkg::OP_DIV;
        req.opa = {{(kcc_pkg::SQ_W-kcc_pkg::DSUM_W){1'b0}}, dsum_r}
                  + {{(kcc_pkg::SQ_W-kcc_pkg::DIST_W){1'b0}}, rsp.result};
        req.opb = count_r;
      end
      S_U_DIV: begin
        req.go  = (cstep_r != 3'd6) && (div_cnt != '0);
        req.op  = kcc_pkg::OP_DIV;
        req.opa = {{(kcc_pkg::SQ_W-kcc_pkg::CSUM_W-8){1'b0}}, sums_r[0], 8'b0};
        req.opb = div_cnt;
      end
      default: begin
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      stop_thr_r   <= 17'd256;
      max_rounds_r <= 8'd64;
      count_r      <= '0;
      idx_r        <= '0;
      run_done_r   <= 1'b0;
      first_r      <= 1'b0;
      use_min_r    <= 1'b0;
      round_r      <= '0;
      status_r     <= kcc_pkg::ST_CONVERGED;
      mstep_r      <= '0;
      cstep_r      <= '0;
      strobe_r     <= 1'b0;
      prev_r       <= '0;
      spread_r     <= '0;
    end else begin
      strobe_r <= 1'b0;
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == kcc_pkg::REG_STOP) begin
          stop_thr_r <= cfg_data;
        end else if (cfg_index == kcc_pkg::REG_MAXR) begin
          max_rounds_r <= cfg_data[7:0];
        end
      end
      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            if (in_action == kcc_pkg::ACT_LOAD) begin
              run_done_r <= 1'b0;
              count_r    <= count_eff + (count_eff[CNT_W-1] ? 1'b0 : 1'b1);
              if (in_last_pixel) begin
                round_r <= '0;
                first_r <= 1'b1;
                idx_r   <= '0;
                state_r <= S_SEED_RD;
              end
            end else if (in_action == kcc_pkg::ACT_LABEL ||
                         in_action == kcc_pkg::ACT_CENTRE) begin
              state_r <= S_RD;
            end
          end
        end
        S_RD: begin
          strobe_r <= 1'b1;
          state_r  <= S_IDLE;
        end
        S_SEED_RD: state_r <= S_SEED_CHK;
        S_SEED_CHK: begin
          if (idx_r != '0 && pix_rdata != seed_r) begin
            idx_r     <= '0;
            use_min_r <= 1'b1;
            state_r   <= S_P_RD;
          end else if (idx_last) begin
            idx_r   <= '0;
            state_r <= S_CLR;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_SEED_RD;
          end
        end
        S_CLR: begin
          idx_r <= idx_r + 1'b1;
          if (idx_last) begin
            status_r <= kcc_pkg::ST_TOO_FEW;
            spread_r <= '0;
            state_r  <= S_FIN;
          end
        end
        S_P_RD:  state_r <= S_P_LAT;
        S_P_LAT: begin
          mstep_r <= '0;
          state_r <= S_P_MUL;
        end
        S_P_MUL: begin
          mstep_r <= mstep_r + 3'd1;
          if (mstep_r == 3'd6) begin
            state_r <= S_P_SQ;
          end
        end
        S_P_SQ: state_r <= S_P_SQW;
        S_P_SQW: begin
          if (rsp.done) begin
            if (idx_last) begin
              state_r <= S_P_DIV;
            end else begin
              idx_r   <= idx_r + 1'b1;
              state_r <= S_P_RD;
            end
          end
        end
        S_P_DIV: begin
          if (rsp.done) begin
            spread_r <= rsp.result;
            state_r  <= S_DECIDE;
          end
        end
        S_DECIDE: begin
          if (!first_r && spread_diff < stop_thr_r) begin
            status_r <= kcc_pkg::ST_CONVERGED;
            state_r  <= S_FIN;
          end else if (round_r >= max_rounds_r) begin
            status_r <= kcc_pkg::ST_LIMIT;
            state_r  <= S_FIN;
          end else begin
            first_r <= 1'b0;
            round_r <= round_r + 8'd1;
            idx_r   <= '0;
            state_r <= S_U_RD;
          end
        end
        S_U_RD: state_r <= S_U_ACC;
        S_U_ACC: begin
          if (idx_last) begin
            cstep_r <= '0;
            state_r <= S_U_DIV;
          end else begin
            idx_r   <= idx_r + 1'b1;
            state_r <= S_U_RD;
          end
        end
        S_U_DIV: begin
          if (cstep_r == 3'd6) begin
            // centres done: spread of the new centres with the old memberships
            prev_r    <= spread_r;
            use_min_r <= 1'b0;
            idx_r     <= '0;
            state_r   <= S_P_RD;
          end else if (div_cnt == '0) begin
            cstep_r <= cstep_r + 3'd1;
          end else begin
            state_r <= S_U_DW;
          end
        end
        S_U_DW: begin
          if (rsp.done) begin
            cstep_r <= cstep_r + 3'd1;
            state_r <= S_U_DIV;
          end
        end
        S_FIN: begin
          prev_r     <= spread_r;
          run_done_r <= 1'b1;
          strobe_r   <= 1'b1;
          state_r    <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // payload registers; centres read as zero until the first run
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int e = 0; e < kcc_pkg::NUM_CEN; e++) begin
        cen_r[e] <= '0;
      end
    end else begin
      if (state_r == S_IDLE && accept) begin
        rd_act_r <= in_action;
        rd_idx_r <= in_index;
        if (in_action == kcc_pkg::ACT_LOAD && in_last_pixel) begin
          // unseeded centres start at zero
          for (int e = 0; e < kcc_pkg::NUM_CEN; e++) begin
            cen_r[e] <= '0;
          end
        end
      end
      if (state_r == S_SEED_CHK) begin
        if (idx_r == '0) begin
          seed_r   <= pix_rdata;
          cen_r[0] <= {pix_rdata[7:0], 8'b0};
          cen_r[1] <= {pix_rdata[15:8], 8'b0};
          cen_r[2] <= {pix_rdata[23:16], 8'b0};
        end else if (pix_rdata != seed_r) begin
          cen_r[3] <= {pix_rdata[7:0], 8'b0};
          cen_r[4] <= {pix_rdata[15:8], 8'b0};
          cen_r[5] <= {pix_rdata[23:16], 8'b0};
          dsum_r   <= '0;
        end
      end
      if (state_r == S_P_LAT) begin
        pix_r <= pix_rdata;
        lab_r <= lab_rdata;
        d0_r  <= '0;
        d1_r  <= '0;
      end
      if (state_r == S_P_MUL) begin
        prod_r <= mul_diff * mul_diff;
        if (mstep_r >= 3'd1 && mstep_r <= 3'd3) begin
          d0_r <= d0_r + {2'b00, prod_r};
        end else if (mstep_r >= 3'd4) begin
          d1_r <= d1_r + {2'b00, prod_r};
        end
      end
      if (state_r == S_P_SQW && rsp.done) begin
        dsum_r <= dsum_r + {{(kcc_pkg::DSUM_W-kcc_pkg::DIST_W){1'b0}}, rsp.result};
      end
      if (state_r == S_DECIDE) begin
        for (int e = 0; e < kcc_pkg::NUM_CEN; e++) begin
          sums_r[e] <= '0;
        end
        mcnt_r[0] <= '0;
        mcnt_r[1] <= '0;
      end
      if (state_r == S_U_ACC) begin
        for (int e = 0; e < kcc_pkg::NUM_CEN; e++) begin
          if ((e >= 3) == lab_rdata) begin
            sums_r[e] <= sums_r[e] + {{(kcc_pkg::CSUM_W-8){1'b0}},
                                      pix_rdata[8*(e%3) +: 8]};
          end
        end
        if (lab_rdata) begin
          mcnt_r[1] <= mcnt_r[1] + 1'b1;
        end else begin
          mcnt_r[0] <= mcnt_r[0] + 1'b1;
        end
      end
      // the channel sums rotate so the divider always reads entry 0
      if ((state_r == S_U_DIV && cstep_r != 3'd6 && div_cnt == '0) ||
          (state_r == S_U_DW && rsp.done)) begin
        for (int e = 0; e < kcc_pkg::NUM_CEN - 1; e++) begin
          sums_r[e] <= sums_r[e+1];
        end
        sums_r[kcc_pkg::NUM_CEN-1] <= sums_r[0];
      end
      if (state_r == S_U_DW && rsp.done) begin
        for (int e = 0; e < kcc_pkg::NUM_CEN; e++) begin
          if (cstep_r == 3'(e)) begin
            cen_r[e] <= rsp.result[15:0];
          end
        end
        dsum_r <= '0;
      end
      if (state_r == S_U_DIV && cstep_r == 3'd6) begin
        dsum_r <= '0;
      end
      // result fields
      if (state_r == S_RD) begin
        olab_r <= (rd_act_r == kcc_pkg::ACT_LABEL) ? lab_rdata : 1'b0;
        if (rd_act_r == kcc_pkg::ACT_CENTRE && rd_idx_r[11:1] == '0) begin
          ocen_r[0] <= rd_idx_r[0] ? cen_r[3] : cen_r[0];
          ocen_r[1] <= rd_idx_r[0] ? cen_r[4] : cen_r[1];
          ocen_r[2] <= rd_idx_r[0] ? cen_r[5] : cen_r[2];
        end else begin
          ocen_r[0] <= '0;
          ocen_r[1] <= '0;
          ocen_r[2] <= '0;
        end
      end
      if (state_r == S_FIN) begin
        olab_r    <= 1'b0;
        ocen_r[0] <= '0;
        ocen_r[1] <= '0;
        ocen_r[2] <= '0;
      end
    end
  end

  assign out_strobe      = strobe_r;
  assign out_label       = olab_r;
  assign out_centre0     = ocen_r[0];
  assign out_centre1     = ocen_r[1];
  assign out_centre2     = ocen_r[2];
  assign out_status      = status_r;
  assign out_rounds_used = round_r;
endmodule

FILE: hw/rtl/kcc_checker.sv
// port level checks for kmeans_color_clustering, bound to the top level
// depends on assert_macros.svh and kcc_pkg
`include "assert_macros.svh"
module kcc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic [1:0]  in_action,
  input logic        in_last_pixel,
  input logic        out_strobe,
  input logic [1:0]  out_status,
  input logic [7:0]  out_rounds_used
);
  logic load_xfer, read_xfer;
  assign load_xfer = start && !busy && in_action == kcc_pkg::ACT_LOAD && !in_last_pixel;
  assign read_xfer = start && !busy && (in_action == kcc_pkg::ACT_LABEL ||
                                        in_action == kcc_pkg::ACT_CENTRE);

  // a plain load finishes in its own transfer cycle
  `KCC_ASSERT_NEXT(a_plain_load, load_xfer, !busy && !out_strobe)
  // a read raises busy in the cycle after its transfer
  `KCC_ASSERT_NEXT(a_read_busy, read_xfer, busy)
  // results never come in adjacent cycles
  `KCC_ASSERT_NEXT(a_strobe_gap, out_strobe, !out_strobe)
  // a too-few result reports no rounds
  `KCC_ASSERT(a_too_few, !out_strobe || out_status != kcc_pkg::ST_TOO_FEW || out_rounds_used == 8'd0)
endmodule

bind kmeans_color_clustering kcc_checker u_kcc_checker (.*);

FILE: bench/tb_top.sv
// testbench for kmeans_color_clustering: loads images, runs clustering, reads labels and centres
// depends on kcc_pkg and the kmeans_color_clustering rtl; predicts every result in-bench
`timescale 1ns / 1ps

module tb_top;
  // action code the block ignores
  localparam logic [1:0] ACT_IDLE_CODE = 2'd3;
  localparam int CYCLE_LIMIT = 8000000;
  localparam int SETTLE_CYCLES = 10;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_action = kcc_pkg::ACT_LOAD;
  logic [7:0]  in_chan0 = '0;
  logic [7:0]  in_chan1 = '0;
  logic [7:0]  in_chan2 = '0;
  logic        in_last_pixel = 1'b0;
  logic [11:0] in_index = '0;
  logic        out_strobe;
  logic        out_label;
  logic [15:0] out_centre0;
  logic [15:0] out_centre1;
  logic [15:0] out_centre2;
  logic [1:0]  out_status;
  logic [7:0]  out_rounds_used;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = kcc_pkg::REG_STOP;
  logic [16:0] cfg_data = '0;

  kmeans_color_clustering dut (.*);

  always #5 clk = ~clk;

  // one result of a read or of a clustering run
  typedef struct {
    bit        label;
    bit [15:0] centre [3];
    bit [1:0]  status;
    bit [7:0]  rounds;
  } cluster_reply_t;

  cluster_reply_t pending_replies[$];
  int  mismatches = 0;
  int  cycle_count = 0;
  int  sender_idle_pct = 0;

  // shadow of the block's state
  bit [23:0]   img_pixels [kcc_pkg::MAX_PIXELS];
  bit          img_labels [kcc_pkg::MAX_PIXELS];
  int unsigned centres [kcc_pkg::NUM_CLUSTERS][3];
  int unsigned img_size = 0;
  int unsigned spread_prev = 0;
  int unsigned round_count = 0;
  bit [1:0]    run_status = kcc_pkg::ST_CONVERGED;
  bit          image_done = 1'b0;
  int unsigned stop_thr = 256;
  int unsigned round_limit = 64;
  // labels 0 .. labels_valid-1 have been written by some run
  int unsigned labels_valid = 0;

  // squared distance between a pixel and a centre, both taken to 8.8
  function automatic longint unsigned dist_sq(bit [23:0] px, int c);
    longint unsigned acc, a, b, d;
    acc = 0;
    for (int ch = 0; ch < 3; ch++) begin
      a = longint'(px[8*ch +: 8]) << 8;
      b = centres[c][ch];
      d = (a > b) ? a - b : b - a;
      acc += d * d;
    end
    return acc;
  endfunction

  function automatic longint unsigned floor_root(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'h4000_0000_0000_0000;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // nearest centre for every pixel, ties to label 0
  function automatic void relabel();
    for (int i = 0; i < img_size; i++)
      img_labels[i] = dist_sq(img_pixels[i], 1) < dist_sq(img_pixels[i], 0);
  endfunction

  function automatic int unsigned mean_spread();
    longint unsigned acc;
    acc = 0;
    if (img_size == 0) return 0;
    for (int i = 0; i < img_size; i++)
      acc += floor_root(dist_sq(img_pixels[i], img_labels[i]));
    return int'(acc / img_size);
  endfunction

  function automatic void recentre();
    longint unsigned sums [kcc_pkg::NUM_CLUSTERS][3];
    int unsigned members [kcc_pkg::NUM_CLUSTERS];
    foreach (members[c]) begin
      members[c] = 0;
      for (int ch = 0; ch < 3; ch++) sums[c][ch] = 0;
    end
    for (int i = 0; i < img_size; i++) begin
      members[img_labels[i]]++;
      for (int ch = 0; ch < 3; ch++) sums[img_labels[i]][ch] += img_pixels[i][8*ch +: 8];
    end
    // an empty cluster keeps its centre
    foreach (members[c])
      if (members[c] != 0)
        for (int ch = 0; ch < 3; ch++) centres[c][ch] = int'((sums[c][ch] << 8) / members[c]);
  endfunction

  function automatic void cluster_image();
    int unsigned seeds, spread, diff;
    bit fresh, first;
    seeds = 0;
    round_count = 0;
    foreach (centres[c, ch]) centres[c][ch] = 0;
    for (int i = 0; i < img_size && seeds < kcc_pkg::NUM_CLUSTERS; i++) begin
      fresh = 1'b1;
      for (int c = 0; c < seeds; c++) if (dist_sq(img_pixels[i], c) == 0) fresh = 1'b0;
      if (fresh) begin
        for (int ch = 0; ch < 3; ch++) centres[seeds][ch] = img_pixels[i][8*ch +: 8] << 8;
        seeds++;
      end
    end
    if (img_size > labels_valid) labels_valid = img_size;
    // fewer distinct pixels than clusters: everything lands in cluster 0
    if (seeds < kcc_pkg::NUM_CLUSTERS) begin
      for (int i = 0; i < img_size; i++) img_labels[i] = 1'b0;
      spread_prev = 0;
      run_status = kcc_pkg::ST_TOO_FEW;
      return;
    end
    relabel();
    spread = mean_spread();
    first = 1'b1;
    forever begin
      if (!first) begin
        diff = (spread > spread_prev) ? spread - spread_prev : spread_prev - spread;
        if (diff < stop_thr) begin
          run_status = kcc_pkg::ST_CONVERGED;
          break;
        end
      end
      if (round_count >= round_limit) begin
        run_status = kcc_pkg::ST_LIMIT;
        break;
      end
      first = 1'b0;
      round_count++;
      recentre();
      spread_prev = spread;
      spread = mean_spread();
      relabel();
    end
    spread_prev = spread;
  endfunction

  // applies one accepted transfer to the shadow state and queues its result, if any
  function automatic void predict_transfer(bit [1:0] act, bit [23:0] px, bit last,
                                           bit [11:0] idx);
    cluster_reply_t r;
    r.label = 1'b0;
    for (int ch = 0; ch < 3; ch++) r.centre[ch] = '0;
    case (act)
      kcc_pkg::ACT_LOAD: begin
        if (image_done) begin
          img_size = 0;
          image_done = 1'b0;
        end
        // loads past a full store are dropped
        if (img_size < kcc_pkg::MAX_PIXELS) begin
          img_pixels[img_size] = px;
          img_size++;
        end
        if (!last) return;
        cluster_image();
        image_done = 1'b1;
      end
      kcc_pkg::ACT_LABEL: r.label = img_labels[idx];
      kcc_pkg::ACT_CENTRE: begin
        if (idx < kcc_pkg::NUM_CLUSTERS)
          for (int ch = 0; ch < 3; ch++) r.centre[ch] = centres[idx][ch][15:0];
      end
      default: return;
    endcase
    r.status = run_status;
    r.rounds = round_count[7:0];
    pending_replies.insert(pending_replies.size(), r);
  endfunction

  // one item transfer; start stays high so a following item goes back to back
  task automatic send_item(bit [1:0] act, bit [23:0] px, bit last, bit [11:0] idx);
    while ($urandom_range(99) < sender_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start         <= 1'b1;
    in_action     <= act;
    in_chan0      <= px[7:0];
    in_chan1      <= px[15:8];
    in_chan2      <= px[23:16];
    in_last_pixel <= last;
    in_index      <= idx;
    do @(posedge clk); while (busy !== 1'b0);
    predict_transfer(act, px, last, idx);
  endtask

  // block idle: waits for all results, then lets the block settle
  task automatic drain();
    start <= 1'b0;
    while (pending_replies.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(bit [1:0] idx, bit [16:0] val);
    drain();
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    cfg_valid <= 1'b0;
    if (idx == kcc_pkg::REG_STOP) stop_thr = val;
    else round_limit = val[7:0];
  endtask

  task automatic report_field(string name, longint exp_v, longint got_v);
    if (exp_v != got_v) begin
      mismatches++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, got_v);
    end
  endtask

  // result checker: the receiver never stalls, every strobe is a transfer
  always @(posedge clk) begin
    cluster_reply_t e;
    if (rst_n && out_strobe === 1'b1) begin
      if (pending_replies.size() == 0) begin
        mismatches++;
        $display("%0t: unexpected result, expected none, actual status %0d", $time, out_status);
      end else begin
        e = pending_replies.pop_front();
        report_field("label", e.label, out_label);
        report_field("centre0", e.centre[0], out_centre0);
        report_field("centre1", e.centre[1], out_centre1);
        report_field("centre2", e.centre[2], out_centre2);
        report_field("status", e.status, out_status);
        report_field("rounds_used", e.rounds, out_rounds_used);
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end
  end

  function automatic bit [23:0] rand_pixel();
    return 24'($urandom);
  endfunction

  // pixel near a base colour, clamped per channel
  function automatic bit [23:0] near_pixel(bit [23:0] base, int spread);
    bit [23:0] px;
    int v;
    for (int ch = 0; ch < 3; ch++) begin
      v = int'(base[8*ch +: 8]) + $urandom_range(2 * spread) - spread;
      if (v < 0) v = 0;
      if (v > 255) v = 255;
      px[8*ch +: 8] = v[7:0];
    end
    return px;
  endfunction

  task automatic read_back(int n_labels);
    for (int i = 0; i < n_labels; i++)
      send_item(kcc_pkg::ACT_LABEL, rand_pixel(), $urandom_range(1),
                12'($urandom_range(labels_valid - 1)));
    send_item(kcc_pkg::ACT_CENTRE, rand_pixel(), 1'b0, 12'd0);
    send_item(kcc_pkg::ACT_CENTRE, rand_pixel(), 1'b0, 12'd1);
  endtask

  // directed corners: extremes, every action, the special cases
  task automatic test_directed();
    // centres before any run, out of range centre, ignored action
    send_item(kcc_pkg::ACT_CENTRE, 24'h0, 1'b0, 12'd0);
    send_item(kcc_pkg::ACT_CENTRE, 24'hFFFFFF, 1'b1, 12'hFFF);
    send_item(ACT_IDLE_CODE, 24'hFFFFFF, 1'b1, 12'hFFF);
    // single pixel image: too few distinct pixels
    send_item(kcc_pkg::ACT_LOAD, 24'hFFFFFF, 1'b1, 12'hFFF);
    send_item(kcc_pkg::ACT_LABEL, 24'h0, 1'b0, 12'd0);
    // repeated pixel: still too few, new image restarts the count
    send_item(kcc_pkg::ACT_LOAD, 24'h123456, 1'b0, 12'd0);
    send_item(kcc_pkg::ACT_LOAD, 24'h123456, 1'b1, 12'd0);
    send_item(kcc_pkg::ACT_CENTRE, 24'h0, 1'b0, 12'd1);
    // black and white extremes with a tie-prone middle pixel
    send_item(kcc_pkg::ACT_LOAD, 24'h000000, 1'b0, 12'd0);
    send_item(kcc_pkg::ACT_LOAD, 24'hFFFFFF, 1'b0, 12'd0);
    send_item(kcc_pkg::ACT_LOAD, 24'h808080, 1'b0, 12'd0);
    send_item(kcc_pkg::ACT_LOAD, 24'h7F7F7F, 1'b1, 12'd0);
    for (int i = 0; i < 4; i++) send_item(kcc_pkg::ACT_LABEL, 24'h0, 1'b0, 12'(i));
    send_item(kcc_pkg::ACT_CENTRE, 24'h0, 1'b0, 12'd0);
    send_item(kcc_pkg::ACT_CENTRE, 24'h0, 1'b0, 12'd2);
    // round limit of one, then a limit of zero
    write_reg(kcc_pkg::REG_MAXR, 17'd1);
    write_reg(kcc_pkg::REG_STOP, 17'd1);
    send_item(kcc_pkg::ACT_LOAD, 24'h0000FF, 1'b0, 12'd0);
    send_item(kcc_pkg::ACT_LOAD, 24'h00FF00, 1'b0, 12'd0);
    send_item(kcc_pkg::ACT_LOAD, 24'hFF0000, 1'b1, 12'd0);
    write_reg(kcc_pkg::REG_MAXR, 17'd0);
    send_item(kcc_pkg::ACT_LOAD, 24'h0000FF, 1'b0, 12'd0);
    send_item(kcc_pkg::ACT_LOAD, 24'hFF0000, 1'b1, 12'd0);
    // largest threshold stops right after the first round
    write_reg(kcc_pkg::REG_MAXR, 17'd255);
    write_reg(kcc_pkg::REG_STOP, 17'd131071);
    send_item(kcc_pkg::ACT_LOAD, 24'h102030, 1'b0, 12'd0);
    send_item(kcc_pkg::ACT_LOAD, 24'hF0E0D0, 1'b1, 12'd0);
    send_item(kcc_pkg::ACT_CENTRE, 24'h0, 1'b0, 12'd1);
    drain();
  endtask

  // more loads than the store holds, the last one still starts the run
  task automatic test_store_full();
    write_reg(kcc_pkg::REG_MAXR, 17'd1);
    write_reg(kcc_pkg::REG_STOP, 17'd256);
    for (int i = 0; i <= kcc_pkg::MAX_PIXELS; i++)
      send_item(kcc_pkg::ACT_LOAD, rand_pixel(), i == kcc_pkg::MAX_PIXELS, 12'($urandom));
    send_item(kcc_pkg::ACT_LABEL, 24'h0, 1'b0, 12'hFFF);
    send_item(kcc_pkg::ACT_LABEL, 24'h0, 1'b0, 12'h800);
    read_back(6);
    drain();
  endtask

  // random images built from two colour clusters, with reads and noise mixed in
  task automatic test_random(int idle_pct, int n_items);
    int sent, n_pix, sel;
    bit [23:0] base_a, base_b, px;
    sender_idle_pct = idle_pct;
    sent = 0;
    while (sent < n_items) begin
      if ($urandom_range(3) == 0) begin
        sel = $urandom_range(3);
        write_reg(kcc_pkg::REG_STOP, sel == 0 ? 17'd1 : sel == 1 ? 17'd131071 :
                  sel == 2 ? 17'd256 : 17'($urandom_range(1, 2048)));
        sel = $urandom_range(9);
        write_reg(kcc_pkg::REG_MAXR, sel == 0 ? 17'd1 : sel == 1 ? 17'd255 :
                  sel == 2 ? 17'd0 : 17'($urandom_range(2, 64)));
      end
      n_pix = ($urandom_range(19) == 0) ? $urandom_range(13, 60) : $urandom_range(1, 12);
      base_a = rand_pixel();
      base_b = ($urandom_range(9) == 0) ? base_a : rand_pixel();
      for (int i = 0; i < n_pix; i++) begin
        sel = $urandom_range(9);
        px = sel == 0 ? rand_pixel() : near_pixel(sel < 5 ? base_a : base_b, 20);
        send_item(kcc_pkg::ACT_LOAD, px, i == n_pix - 1, 12'($urandom));
        sent++;
        // reads and ignored items slipped into the load sequence
        if ($urandom_range(7) == 0) begin
          sel = $urandom_range(2);
          if (sel == 0 && labels_valid > 0)
            send_item(kcc_pkg::ACT_LABEL, rand_pixel(), 1'b0,
                      12'($urandom_range(labels_valid - 1)));
          else if (sel == 1)
            send_item(kcc_pkg::ACT_CENTRE, rand_pixel(), $urandom_range(1), 12'($urandom));
          else
            send_item(ACT_IDLE_CODE, rand_pixel(), $urandom_range(1), 12'($urandom));
        end
      end
      sel = $urandom_range(1, 4);
      read_back(sel);
      sent += sel + 2;
    end
    drain();
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_store_full();
    test_random(32, 600);
    test_random(87, 600);
    test_random(0, 600);
    drain();
    if (mismatches == 0) begin
      $display("tb_top OK");
    end else begin
      $display("tb_top NOT OK");
    end
    $finish;
  end
endmodule
